// ===== hdl/aes256_pkg.sv =====
package aes256_pkg;

  localparam int NumRounds = 14;
  localparam int KeyWords  = 30;
  localparam int KeyIdxW   = 5;

  localparam logic OP_LOAD    = 1'b0;
  localparam logic OP_ENCRYPT = 1'b1;

  typedef logic [127:0] state_t;
  typedef logic [63:0]  word_t;

  localparam logic [7:0] SBOX [256] = '{
    8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
    8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
    8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
    8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
    8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
    8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
    8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
    8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
    8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
    8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
    8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
    8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
    8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
    8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
    8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
    8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
  };

  function automatic logic [7:0] xtime(input logic [7:0] a);
    xtime = {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
  endfunction

  // SubBytes then ShiftRows; byte 4*row+col, row rotates left by row
  function automatic state_t sub_shift(input state_t s);
    state_t t;
    for (int r = 0; r < 4; r++) begin
      for (int c = 0; c < 4; c++) begin
        t[8*(4*r+c) +: 8] = SBOX[s[8*(4*r+((c+r)%4)) +: 8]];
      end
    end
    sub_shift = t;
  endfunction

  function automatic state_t mix_columns(input state_t s);
    state_t t;
    logic [7:0] a0, a1, a2, a3, d0, d1, d2, d3;
    for (int c = 0; c < 4; c++) begin
      a0 = s[8*c +: 8];      a1 = s[8*(4+c) +: 8];
      a2 = s[8*(8+c) +: 8];  a3 = s[8*(12+c) +: 8];
      d0 = xtime(a0); d1 = xtime(a1); d2 = xtime(a2); d3 = xtime(a3);
      t[8*c +: 8]      = d0 ^ d1 ^ a1 ^ a2 ^ a3;
      t[8*(4+c) +: 8]  = a0 ^ d1 ^ d2 ^ a2 ^ a3;
      t[8*(8+c) +: 8]  = a0 ^ a1 ^ d2 ^ d3 ^ a3;
      t[8*(12+c) +: 8] = d0 ^ a0 ^ a1 ^ a2 ^ d3;
    end
    mix_columns = t;
  endfunction

endpackage

// ===== hdl/aes256_round.sv =====
// One pipeline stage: a full round (or the final one without MixColumns).
module aes256_round (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   adv,
  input  logic                   final_rnd,
  input  logic                   vld_in,
  input  logic                   last_in,
  input  aes256_pkg::state_t     st_in,
  input  aes256_pkg::state_t     rk,
  output logic                   vld_out,
  output logic                   last_out,
  output aes256_pkg::state_t     st_out
);

  aes256_pkg::state_t ss, mc;

  always_comb begin
    ss = aes256_pkg::sub_shift(st_in);
    mc = final_rnd ? ss : aes256_pkg::mix_columns(ss);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld_out <= 1'b0;
    end else if (adv) begin
      vld_out <= vld_in;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      st_out   <= mc ^ rk;
      last_out <= last_in;
    end
  end

endmodule

// ===== hdl/aes256_block_encrypt.sv =====
// AES-256 encryption of independent 128-bit blocks with an expanded key
// loaded from outside. opcode 0 writes one 64-bit word (index 0..29) of the
// 240-byte round-key store and produces no output transaction; indexes 30
// and 31 are dropped. opcode 1 encrypts one block and produces one output
// transaction, in order. Load all 30 key words before the first encrypt;
// a load while encrypts are in flight changes keys seen by those blocks.
// The datapath is a 15-stage pipeline (initial AddRoundKey, 13 full rounds,
// final round), one register stage per round, so an encrypt can enter every
// cycle while the pipe advances. The whole pipe stalls when the output stage
// is full and not taken; in_ready is the pipe's advance.
// Round keys sit in flip-flops, each stage reading its own fixed pair.
module aes256_block_encrypt (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        opcode,
  input  logic [4:0]  key_index,
  input  logic [63:0] key_word,
  input  logic [63:0] block_lo,
  input  logic [63:0] block_hi,
  input  logic        last_block,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [63:0] cipher_lo,
  output logic [63:0] cipher_hi,
  output logic        last_out
);

  localparam int Stages = aes256_pkg::NumRounds + 1;

  aes256_pkg::word_t  rks [aes256_pkg::KeyWords];
  aes256_pkg::state_t st  [Stages];
  logic               vld [Stages];
  logic               lst [Stages];
  logic               adv;
  logic               enc_acc;

  // pipe moves when the tail stage is empty or being drained
  assign adv      = !vld[Stages-1] || out_ready;
  assign in_ready = adv;
  assign enc_acc  = in_valid && in_ready && (opcode == aes256_pkg::OP_ENCRYPT);

  always_ff @(posedge clk) begin
    if (in_valid && in_ready && opcode == aes256_pkg::OP_LOAD &&
        key_index < aes256_pkg::KeyIdxW'(aes256_pkg::KeyWords)) begin
      rks[key_index] <= key_word;
    end
  end

  // stage 0: initial AddRoundKey
  always_ff @(posedge clk) begin
    if (rst) begin
      vld[0] <= 1'b0;
    end else if (adv) begin
      vld[0] <= enc_acc;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      st[0]  <= {block_hi, block_lo} ^ {rks[1], rks[0]};
      lst[0] <= last_block;
    end
  end

  for (genvar r = 1; r < Stages; r++) begin : g_rnd
    aes256_round u_rnd (
      .clk      (clk),
      .rst      (rst),
      .adv      (adv),
      .final_rnd(r == Stages - 1),
      .vld_in   (vld[r-1]),
      .last_in  (lst[r-1]),
      .st_in    (st[r-1]),
      .rk       ({rks[2*r+1], rks[2*r]}),
      .vld_out  (vld[r]),
      .last_out (lst[r]),
      .st_out   (st[r])
    );
  end

  assign out_valid = vld[Stages-1];
  assign cipher_lo = st[Stages-1][63:0];
  assign cipher_hi = st[Stages-1][127:64];
  assign last_out  = lst[Stages-1];

  // a stalled result must hold
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(cipher_lo) && $stable(cipher_hi))
    else $error("result changed while stalled");

  // ready drops only when the tail stage is full
  a_rdy: assert property (@(posedge clk) disable iff (rst)
    !in_ready |-> out_valid && !out_ready)
    else $error("pipe stalled without back-pressure");

  // a load never creates a result
  a_load: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && opcode == aes256_pkg::OP_LOAD |=> !vld[0])
    else $error("load entered the pipe");

endmodule

// ===== test/tb_aes256_block_encrypt.sv =====
`timescale 1ns / 100ps

module tb_aes256_block_encrypt;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic        opcode = aes256_pkg::OP_LOAD;
  logic [4:0]  key_index = '0;
  logic [63:0] key_word = '0;
  logic [63:0] block_lo = '0;
  logic [63:0] block_hi = '0;
  logic        last_block = 1'b0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [63:0] cipher_lo;
  logic [63:0] cipher_hi;
  logic        last_out;

  aes256_block_encrypt dut (.*);

  always #5 clk = ~clk;

  // One row of the directed stimulus
  typedef struct packed {
    logic        op;
    logic [4:0]  idx;
    logic [63:0] kw;
    logic [63:0] lo;
    logic [63:0] hi;
    logic        last;
  } stim_row_t;

  typedef struct packed {
    logic [63:0] lo;
    logic [63:0] hi;
    logic        last;
  } cipher_t;

  localparam int Latency = 15;
  localparam int NumDirected = 14;
  localparam logic [63:0] Ones = 64'hffff_ffff_ffff_ffff;
  localparam logic [63:0] Alt  = 64'haaaa_aaaa_aaaa_aaaa;
  localparam logic OpLd = aes256_pkg::OP_LOAD;
  localparam logic OpEn = aes256_pkg::OP_ENCRYPT;

  // Loads of a valid index sit only at the start, before any block is in flight.
  localparam stim_row_t DirectedTab [NumDirected] = '{
    '{OpLd, 5'd0,  Ones, Ones, Ones, 1'b1},  // load ignores block fields
    '{OpLd, 5'd29, '0,   Alt,  ~Alt, 1'b1},
    '{OpEn, 5'd31, Ones, '0,   '0,   1'b0},  // encrypt ignores key fields
    '{OpEn, 5'd0,  '0,   Ones, Ones, 1'b1},
    '{OpEn, 5'd30, Alt,  Alt,  ~Alt, 1'b0},
    '{OpEn, 5'd15, ~Alt, ~Alt, Alt,  1'b1},
    '{OpLd, 5'd30, Ones, '0,   '0,   1'b0},  // out-of-range index dropped
    '{OpLd, 5'd31, Ones, Ones, Ones, 1'b1},
    '{OpEn, 5'd0,  '0,   '0,   '0,   1'b1},
    '{OpEn, 5'd0,  '0,   64'h1, '0,  1'b0},
    '{OpEn, 5'd0,  '0,   '0,   64'h8000_0000_0000_0000, 1'b0},
    '{OpLd, 5'd30, '0,   Alt,  Alt,  1'b0},
    '{OpEn, 5'd0,  '0,   64'h0011_2233_4455_6677, 64'h8899_aabb_ccdd_eeff, 1'b1},
    '{OpEn, 5'd0,  '0,   Ones, '0,   1'b0}
  };

  // Testbench copy of the round-key store
  logic [63:0] round_keys [aes256_pkg::KeyWords];
  cipher_t     cipher_q [$];

  int snd_idle_pct = 0;
  int rcv_stall_pct = 0;
  bit hold_go = 1'b0;
  int hold_left = 0;
  int mismatches = 0;
  int stray = 0;
  int n_cipher = 0;
  int n_sent = 0;

  function automatic logic [7:0] gmul2(input logic [7:0] a);
    return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
  endfunction

  function automatic logic [127:0] round_key(input int r);
    logic [63:0] klo, khi;
    klo = (2*r < aes256_pkg::KeyWords) ? round_keys[2*r] : '0;
    khi = (2*r+1 < aes256_pkg::KeyWords) ? round_keys[2*r+1] : '0;
    return {khi, klo};
  endfunction

  // Full AES-256 flow on the row-major state, byte 4*row+col at bit 8*(4*row+col)
  function automatic logic [127:0] aes_encrypt(input logic [127:0] pt);
    logic [127:0] s, t;
    logic [7:0]   a0, a1, a2, a3;
    s = pt ^ round_key(0);
    for (int rnd = 1; rnd <= aes256_pkg::NumRounds; rnd++) begin
      for (int r = 0; r < 4; r++)
        for (int c = 0; c < 4; c++)
          t[8*(4*r+c) +: 8] = aes256_pkg::SBOX[s[8*(4*r+((c+r)&3)) +: 8]];
      s = t;
      if (rnd < aes256_pkg::NumRounds) begin
        for (int c = 0; c < 4; c++) begin
          a0 = t[8*c +: 8];     a1 = t[8*(4+c) +: 8];
          a2 = t[8*(8+c) +: 8]; a3 = t[8*(12+c) +: 8];
          s[8*c +: 8]      = gmul2(a0) ^ gmul2(a1) ^ a1 ^ a2 ^ a3;
          s[8*(4+c) +: 8]  = a0 ^ gmul2(a1) ^ gmul2(a2) ^ a2 ^ a3;
          s[8*(8+c) +: 8]  = a0 ^ a1 ^ gmul2(a2) ^ gmul2(a3) ^ a3;
          s[8*(12+c) +: 8] = gmul2(a0) ^ a0 ^ a1 ^ a2 ^ gmul2(a3);
        end
      end
      s = s ^ round_key(rnd);
    end
    return s;
  endfunction

  function automatic logic [63:0] rand64();
    return {$urandom(), $urandom()};
  endfunction

  // Offer one transaction; on acceptance update the key copy or queue the cipher.
  task automatic send(input stim_row_t row);
    cipher_t c;
    if ($urandom_range(99) < snd_idle_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(6, 1)) @(posedge clk);
    end
    in_valid   <= 1'b1;
    opcode     <= row.op;
    key_index  <= row.idx;
    key_word   <= row.kw;
    block_lo   <= row.lo;
    block_hi   <= row.hi;
    last_block <= row.last;
    do @(posedge clk); while (!in_ready);
    n_sent++;
    if (row.op == aes256_pkg::OP_LOAD) begin
      if (row.idx < aes256_pkg::KeyWords) round_keys[row.idx] = row.kw;
    end else begin
      {c.hi, c.lo} = aes_encrypt({row.hi, row.lo});
      c.last = row.last;
      cipher_q.push_back(c);
    end
  endtask

  // Pipe must be empty before touching keys, or in-flight blocks see the new ones
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (cipher_q.size() != 0) @(posedge clk);
    repeat (Latency + 5) @(posedge clk);
  endtask

  task automatic load_keys(input int style);
    stim_row_t row;
    for (int w = 0; w < aes256_pkg::KeyWords; w++) begin
      row = '{OpLd, w[4:0], rand64(), rand64(), rand64(), 1'($urandom)};
      if (style == 1) row.kw = Ones;
      if (style == 2) row.kw = '0;
      send(row);
      // occasional dropped index in among the loads
      if ($urandom_range(9) == 0) begin
        row.idx = 5'(30 + $urandom_range(1));
        send(row);
      end
    end
  endtask

  function automatic logic [63:0] rand_block();
    case ($urandom_range(7))
      0: return '0;
      1: return Ones;
      default: return rand64();
    endcase
  endfunction

  // Receiver: random stalls, plus a long hold-off on request
  always @(posedge clk) begin
    if (hold_go) begin
      hold_go = 1'b0;
      hold_left = 300;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= rcv_stall_pct);
    end
  end

  // Check each output transaction against the oldest queued cipher
  always @(posedge clk) begin
    cipher_t want;
    if (!rst && out_valid && out_ready) begin
      if (cipher_q.size() == 0) begin
        stray++;
        $display("unexpected output: %h %h last=%b", cipher_hi, cipher_lo, last_out);
      end else begin
        want = cipher_q.pop_front();
        n_cipher++;
        if (want.lo !== cipher_lo || want.hi !== cipher_hi || want.last !== last_out) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: exp %h %h last=%b got %h %h last=%b",
                     want.hi, want.lo, want.last, cipher_hi, cipher_lo, last_out);
        end
      end
    end
  end

  initial begin
    #20_000_000;
    $display("TB_ERROR");
    $finish;
  end

  initial begin
    stim_row_t row;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: all-ones keys, then the table; all-zero keys, then the table from its third row
    load_keys(1);
    for (int i = 0; i < NumDirected; i++) send(DirectedTab[i]);
    drain();
    load_keys(2);
    for (int i = 2; i < NumDirected; i++) send(DirectedTab[i]);
    drain();

    // Random: fresh key set per phase, idling mode rotating through the four
    for (int ph = 0; ph < 12; ph++) begin
      case (ph % 4)
        0: begin snd_idle_pct = 0;  rcv_stall_pct = 0;  end
        1: begin snd_idle_pct = 87; rcv_stall_pct = 0;  end
        2: begin snd_idle_pct = 0;  rcv_stall_pct = 87; end
        default: begin snd_idle_pct = 33; rcv_stall_pct = 33; end
      endcase
      load_keys(0);
      for (int n = 0; n < 70; n++) begin
        if (n == 10 && ph % 4 == 0) hold_go = 1'b1;  // fill the pipe, stall input
        row = '{OpEn, 5'($urandom), rand64(), rand_block(), rand_block(),
                1'($urandom)};
        // out-of-range loads are harmless mid-stream
        if ($urandom_range(19) == 0) begin
          row.op = aes256_pkg::OP_LOAD;
          row.idx = 5'(30 + $urandom_range(1));
        end
        send(row);
      end
      drain();  // sender waits for every cipher before the next key set
    end

    repeat (Latency + 20) @(posedge clk);
    $display("sent %0d transactions, checked %0d ciphertexts over 14 key sets",
             n_sent, n_cipher);
    $display("idling modes: none, sender, receiver, both; long receiver hold-off");
    if (mismatches == 0 && stray == 0 && cipher_q.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
